// ----- rtl/spq_pkg.sv -----
// shared types and constants of the sorted priority queue
package spq_pkg;

  localparam int unsigned QueueDepthDefault = 128;
  localparam int unsigned DataWidth         = 32;
  localparam int unsigned OccWidth          = 8;

  // operation codes
  localparam logic FuncEnqueue = 1'b0;
  localparam logic FuncDequeue = 1'b1;

  // result status codes
  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  typedef struct packed {
    logic                        func;
    logic signed [DataWidth-1:0] item_value;
    logic signed [DataWidth-1:0] item_priority;
  } req_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [DataWidth-1:0] head_value;
    logic [OccWidth-1:0]         occupancy;
  } rsp_t;

  // one stored entry
  typedef struct packed {
    logic signed [DataWidth-1:0] val;
    logic signed [DataWidth-1:0] key;
  } entry_t;

  // per-cycle control for each cell: enq and deq are broadcast, valid is per cell
  typedef struct packed {
    logic enq;
    logic deq;
    logic valid;
  } cell_ctl_t;

endpackage

// ----- rtl/spq_cell.sv -----
// one cell of the sorted shift chain
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t   new_entry,
  input  spq_pkg::entry_t   left_entry,
  input  logic              left_gt,
  input  spq_pkg::entry_t   right_entry,
  output spq_pkg::entry_t   entry,
  output logic              gt
);

  // an empty cell ranks behind everything
  assign gt = !ctl.valid || (entry.key > new_entry.key);

  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      if (gt) begin
        entry <= left_gt ? left_entry : new_entry;
      end
    end else if (ctl.deq) begin
      entry <= right_entry;
    end
  end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// top level of the sorted priority queue built as a chain of cells
//
// usage
//   one command word on req, taken at a clock edge where start is high and
//   busy is low; busy never rises, so a word may be given in every cycle
//   req.func selects enqueue (value and priority) or dequeue of the head
//   one result word follows per command on result, marked by done for
//   exactly one cycle, in the cycle after the command was taken
//   throughput 1 command per cycle: every cell compares its key with the
//   new priority at once and the whole row shifts in the same edge, so the
//   cell update sets the rate
//   the receiver cannot stall; it must take each result as it comes
//   status reports done, dequeue from an empty queue, or an enqueue
//   dropped because the queue is full; occupancy is the entry count after
//   the command, in its low 8 bits
//   reset (rst, synchronous, active high) empties the queue and clears
//   done; the cell contents are not cleared and are never read while empty
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t req,
  output logic          done,
  output spq_pkg::rsp_t result
);

  localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);

  logic [CntWidth-1:0] count;
  logic [CntWidth-1:0] count_next;
  logic                is_full;
  logic                is_empty;
  logic                do_enq;
  logic                do_deq;
  spq_pkg::entry_t     new_entry;
  spq_pkg::entry_t     entries [QUEUE_DEPTH];
  logic                gts     [QUEUE_DEPTH];

  // the block is always ready for the next word
  assign busy = 1'b0;

  assign is_full  = (count == CntWidth'(QUEUE_DEPTH));
  assign is_empty = (count == '0);
  assign do_enq   = start && (req.func == spq_pkg::FuncEnqueue) && !is_full;
  assign do_deq   = start && (req.func == spq_pkg::FuncDequeue) && !is_empty;

  assign new_entry.val = req.item_value;
  assign new_entry.key = req.item_priority;

  // chain of cells: head at index 0, smallest priority number first
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::cell_ctl_t ctl;
    spq_pkg::entry_t    left_entry;
    spq_pkg::entry_t    right_entry;
    logic               left_gt;

    assign ctl.enq   = do_enq;
    assign ctl.deq   = do_deq;
    assign ctl.valid = (CntWidth'(i) < count);

    // the head cell has no left neighbour: it ranks as never greater
    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_gt    = gts[i-1];
    end

    // the tail cell pulls in nothing meaningful on a dequeue
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .left_gt     (left_gt),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .gt          (gts[i])
    );
  end

  always_comb begin
    count_next = count;
    if (do_enq) begin
      count_next = count + CntWidth'(1);
    end else if (do_deq) begin
      count_next = count - CntWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= start;
    end
  end

  // result word, registered
  always_ff @(posedge clk) begin
    if (start) begin
      result.occupancy  <= spq_pkg::OccWidth'(count_next);
      result.head_value <= '0;
      if (req.func == spq_pkg::FuncEnqueue) begin
        result.status <= is_full ? spq_pkg::StatusFull : spq_pkg::StatusDone;
      end else begin
        result.status <= is_empty ? spq_pkg::StatusEmpty : spq_pkg::StatusDone;
        if (!is_empty) begin
          result.head_value <= entries[0].val;
        end
      end
    end
  end

  // every taken command yields exactly one result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("command without result");

  // the count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntWidth'(QUEUE_DEPTH))
    else $error("entry count above depth");

  // a successful dequeue removes exactly one entry
  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    do_deq |=> (count == $past(count) - CntWidth'(1)))
    else $error("dequeue did not remove one entry");

  // an error status leaves the count unchanged
  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    (start && !do_enq && !do_deq) |=> $stable(count))
    else $error("rejected command changed the count");

endmodule

// ----- tb/spq_checker.sv -----
// checker for the sorted priority queue: predicts each result word and compares it
module spq_checker #(
  parameter int unsigned Depth = spq_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  spq_pkg::req_t req,
  input  logic          done,
  input  spq_pkg::rsp_t result,
  output int unsigned   bad_results,
  output int unsigned   pending
);

  logic signed [spq_pkg::DataWidth-1:0] held_val [Depth];
  logic signed [spq_pkg::DataWidth-1:0] held_key [Depth];
  int unsigned held_count;
  spq_pkg::rsp_t awaited_results [$];

  // applies one command word to the local queue and returns its result word
  function automatic spq_pkg::rsp_t apply_command(input spq_pkg::req_t cmd);
    spq_pkg::rsp_t outcome;
    int unsigned   pos;
    outcome = '0;
    if (cmd.func == spq_pkg::FuncEnqueue) begin
      if (held_count >= Depth) begin
        outcome.status = spq_pkg::StatusFull;
      end else begin
        // behind every entry of lower or equal priority number
        pos = 0;
        while (pos < held_count && $signed(held_key[pos]) <= $signed(cmd.item_priority))
          pos++;
        for (int unsigned i = held_count; i > pos; i--) begin
          held_val[i] = held_val[i-1];
          held_key[i] = held_key[i-1];
        end
        held_val[pos] = cmd.item_value;
        held_key[pos] = cmd.item_priority;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        outcome.status = spq_pkg::StatusEmpty;
      end else begin
        outcome.head_value = held_val[0];
        for (int unsigned i = 1; i < held_count; i++) begin
          held_val[i-1] = held_val[i];
          held_key[i-1] = held_key[i];
        end
        held_count--;
      end
    end
    outcome.occupancy = spq_pkg::OccWidth'(held_count);
    return outcome;
  endfunction

  always @(posedge clk) begin
    spq_pkg::rsp_t want;
    if (rst) begin
      held_count  = 0;
      bad_results = 0;
      awaited_results.delete();
    end else begin
      // a result word belongs to a command taken at an earlier edge
      if (done) begin
        if (awaited_results.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("unexpected result word: status %0d head %0d occupancy %0d",
                     result.status, result.head_value, result.occupancy);
        end else begin
          want = awaited_results.pop_front();
          if (result.status !== want.status || result.head_value !== want.head_value ||
              result.occupancy !== want.occupancy) begin
            bad_results++;
            if (bad_results <= 10)
              $display("result mismatch: expected status %0d head %0d occupancy %0d, %s",
                       want.status, want.head_value, want.occupancy,
                       $sformatf("got status %0d head %0d occupancy %0d",
                                 result.status, result.head_value, result.occupancy));
          end
        end
      end
      if (start && !busy)
        awaited_results.push_back(apply_command(req));
    end
    pending = awaited_results.size();
  end

endmodule

// ----- tb/tb.sv -----
// testbench top for the sorted priority queue: stimulus, clock, reset and verdict
module tb;

  localparam logic signed [spq_pkg::DataWidth-1:0] MinWord = 32'sh8000_0000;
  localparam logic signed [spq_pkg::DataWidth-1:0] MaxWord = 32'sh7fff_ffff;
  // watchdog limit, set far above the length of the slowest correct run
  localparam int unsigned CycleLimit = 200000;

  logic          clk   = 1'b0;
  logic          rst   = 1'b1;
  logic          start = 1'b0;
  spq_pkg::req_t req   = '0;
  logic          busy;
  logic          done;
  spq_pkg::rsp_t result;
  int unsigned   bad_results;
  int unsigned   pending;
  int unsigned   cycle_count = 0;

  always #5 clk = ~clk;

  sorted_priority_queue dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .result(result)
  );

  spq_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .result     (result),
    .bad_results(bad_results),
    .pending    (pending)
  );

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // offers one command word from a falling edge and holds it until taken;
  // busy is read at the rising edge, before the block updates it
  task automatic issue_word(input logic func,
                            input logic signed [spq_pkg::DataWidth-1:0] value,
                            input logic signed [spq_pkg::DataWidth-1:0] prio);
    start <= 1'b1;
    req   <= '{func: func, item_value: value, item_priority: prio};
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // sender gap; the bus carries junk while start is low
  task automatic pause_sender(input int unsigned gap);
    start <= 1'b0;
    req   <= '{func: 1'($urandom), item_value: $urandom, item_priority: $urandom};
    repeat (gap) @(negedge clk);
  endtask

  // hold off until every outstanding result word has come back
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // tight priorities to force ties, some extremes, full range as often as tight
  function automatic logic signed [spq_pkg::DataWidth-1:0] pick_priority();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45)
      return spq_pkg::DataWidth'($urandom_range(8)) - 4;
    if (roll < 55) begin
      case ($urandom_range(3))
        0:       return MinWord;
        1:       return MaxWord;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // random phases: share of enqueues, length, and chance of a gap per word
  int unsigned enq_share  [5] = '{95, 5, 60, 40, 50};
  int unsigned phase_len  [5] = '{220, 200, 250, 250, 180};
  int unsigned idle_share [5] = '{15, 30, 10, 20, 0};

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part
    // dequeue from an empty queue
    issue_word(spq_pkg::FuncDequeue, MaxWord, MinWord);
    // extremes of value and priority
    issue_word(spq_pkg::FuncEnqueue, MaxWord, '0);
    issue_word(spq_pkg::FuncEnqueue, MinWord, MaxWord);
    issue_word(spq_pkg::FuncEnqueue, '0, MinWord);
    issue_word(spq_pkg::FuncEnqueue, '1, '1);
    // equal priorities must leave first in, first out
    issue_word(spq_pkg::FuncEnqueue, 32'sh5555_5555, '0);
    issue_word(spq_pkg::FuncEnqueue, 32'shAAAA_AAAA, '0);
    issue_word(spq_pkg::FuncEnqueue, 32'sd7, '0);
    issue_word(spq_pkg::FuncEnqueue, 32'sd8, MaxWord);
    issue_word(spq_pkg::FuncEnqueue, 32'sd9, MinWord);
    repeat (9) issue_word(spq_pkg::FuncDequeue, $urandom, $urandom);
    // and empty again
    issue_word(spq_pkg::FuncDequeue, '0, '0);
    issue_word(spq_pkg::FuncDequeue, '1, '1);

    // sender waits for everything outstanding before the random part
    drain_results();

    // random part: fill to full, drain to empty, then mixed traffic
    for (int ph = 0; ph < 5; ph++) begin
      for (int unsigned n = 0; n < phase_len[ph]; n++) begin
        if ($urandom_range(99) < idle_share[ph])
          pause_sender($urandom_range(1, 11));
        if ($urandom_range(99) < enq_share[ph])
          issue_word(spq_pkg::FuncEnqueue, $urandom, pick_priority());
        else
          issue_word(spq_pkg::FuncDequeue, $urandom, $urandom);
      end
      // a second full stop in the middle of the run
      if (ph == 2)
        drain_results();
    end

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    // room for any stray word after the last one expected
    repeat (4) @(negedge clk);

    if (bad_results == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
